// ===== src/ifr_pkg.sv =====
// ============================================================================
// ifr_pkg
// Shared types and constants of the information frame receiver.
// ============================================================================
`default_nettype none

package ifr_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_KEY   = 8'h20;
    localparam logic [7:0] CTRL_I0   = 8'h00;
    localparam logic [7:0] CTRL_SEQ  = 8'h40;
    localparam logic [7:0] CTRL_DISC = 8'h0B;

    localparam logic [7:0] PEER_ADDR_RST = 8'h03;

    localparam int LEN_W = 11;

    // parse phases
    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_DATA = 3'd4,
        PH_SKIP = 3'd5
    } t_phase;

    // verdict codes; RR/REJ carry the next sequence bit in bit 0
    typedef enum logic [2:0] {
        VD_RR0  = 3'd0,
        VD_RR1  = 3'd1,
        VD_REJ0 = 3'd2,
        VD_REJ1 = 3'd3,
        VD_DISC = 3'd4
    } t_verdict;

endpackage

`default_nettype wire

// ===== src/information_frame_receiver_core.sv =====
// ============================================================================
// information_frame_receiver_core
// Byte-stuffed HDLC-like frame receiver with payload output and verdicts.
// ============================================================================
// Usage:
//   Input channel (i_rx_valid / o_rx_ready / i_rx_byte): one raw line byte
//   per word. Output channel (o_out_valid / i_out_ready): either a destuffed
//   payload byte (o_is_frame_end = 0) or the frame verdict with the payload
//   length (o_is_frame_end = 1). Payload bytes are released one byte late,
//   so the trailing XOR check byte never shows up on the output.
//   Config: i_cfg_we loads i_cfg_data as the expected peer address; write
//   only while the block is idle.
// Timing:
//   One byte accepted per cycle while o_rx_ready is high. The state update
//   for a byte is a single pass of logic from the input port to the state
//   and output registers, so a result appears in the cycle after the byte
//   that causes it is accepted. The output register refills in the cycle it
//   is drained, so the block runs at full rate while the sink takes words.
// Stall: while a result waits in the output register and i_out_ready is
//   low, o_rx_ready drops; bytes that give no result are held off too.
// Reset: synchronous, active low. Parser returns to hunting for an opening
//   flag, sequence bit clears, peer address returns to 3, output empties.
// ============================================================================
`default_nettype none

module information_frame_receiver_core #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration
    input  wire logic                      i_cfg_we,
    input  wire logic [7:0]                i_cfg_data,
    // line bytes in
    input  wire logic                      i_rx_valid,
    output logic                           o_rx_ready,
    input  wire logic [7:0]                i_rx_byte,
    // results out
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_is_frame_end,
    output logic [7:0]                     o_payload_byte,
    output logic [2:0]                     o_verdict,
    output logic [ifr_pkg::LEN_W-1:0]      o_payload_length
);

    import ifr_pkg::*;

    // count must reach MAX_PAYLOAD itself
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAYLOAD);

    // parser state
    t_phase         r_phase,     n_phase;
    logic [7:0]     r_hdr_xor,   n_hdr_xor;
    logic           r_seq,       n_seq;
    logic           r_disc,      n_disc;
    logic           r_esc,       n_esc;
    logic [7:0]     r_held,      n_held;
    logic           r_held_vld,  n_held_vld;
    logic [7:0]     r_run_xor,   n_run_xor;
    logic [CW-1:0]  r_count,     n_count;
    logic [7:0]     r_peer;

    // output register
    logic             r_out_valid;
    logic             r_is_end;
    logic [7:0]       r_pay;
    logic [2:0]       r_verdict;
    logic [LEN_W-1:0] r_len;

    // result of the current byte
    logic             w_emit;
    logic             w_emit_end;
    logic [7:0]       w_emit_pay;
    logic [2:0]       w_emit_vd;
    logic [LEN_W-1:0] w_emit_len;

    logic       w_accept;
    logic       w_good;
    logic [7:0] w_dbyte;

    // output slot is free, or frees this cycle
    assign o_rx_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_rx_valid && o_rx_ready;

    assign w_dbyte = r_esc ? (i_rx_byte ^ ESC_KEY) : i_rx_byte;
    assign w_good  = !r_esc && r_held_vld && (r_held == r_run_xor);

    always_comb begin
        n_phase    = r_phase;
        n_hdr_xor  = r_hdr_xor;
        n_seq      = r_seq;
        n_disc     = r_disc;
        n_esc      = r_esc;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        n_run_xor  = r_run_xor;
        n_count    = r_count;
        w_emit     = 1'b0;
        w_emit_end = 1'b0;
        w_emit_pay = 8'h00;
        w_emit_vd  = VD_RR0;
        w_emit_len = '0;

        case (r_phase)
            PH_FLAG: begin
                // address is tested before the flag
                if (i_rx_byte == r_peer) begin
                    n_hdr_xor = i_rx_byte;
                    n_phase   = PH_ADDR;
                end else if (i_rx_byte != FLAG_BYTE) begin
                    n_phase = PH_WAIT;
                end
            end
            PH_ADDR: begin
                if (i_rx_byte == CTRL_I0 || i_rx_byte == CTRL_SEQ) begin
                    n_seq     = (i_rx_byte == CTRL_I0);
                    n_disc    = 1'b0;
                    n_hdr_xor = r_hdr_xor ^ i_rx_byte;
                    n_phase   = PH_CTRL;
                end else if (i_rx_byte == CTRL_DISC) begin
                    n_disc    = 1'b1;
                    n_hdr_xor = r_hdr_xor ^ i_rx_byte;
                    n_phase   = PH_CTRL;
                end else begin
                    n_phase = (i_rx_byte == FLAG_BYTE) ? PH_FLAG : PH_WAIT;
                end
            end
            PH_CTRL: begin
                if (i_rx_byte == r_hdr_xor) begin
                    n_esc      = 1'b0;
                    n_held     = 8'h00;
                    n_held_vld = 1'b0;
                    n_run_xor  = 8'h00;
                    n_count    = '0;
                    n_phase    = r_disc ? PH_SKIP : PH_DATA;
                end else begin
                    n_disc  = 1'b0;
                    n_phase = (i_rx_byte == FLAG_BYTE) ? PH_FLAG : PH_WAIT;
                end
            end
            PH_SKIP, PH_DATA: begin
                if (i_rx_byte == FLAG_BYTE) begin
                    // closing flag: verdict, then hunt again
                    w_emit     = 1'b1;
                    w_emit_end = 1'b1;
                    if (r_disc) begin
                        w_emit_vd = VD_DISC;
                    end else begin
                        w_emit_vd  = ((r_phase == PH_DATA) && w_good)
                                     ? {2'b00, r_seq} : {2'b01, r_seq};
                        w_emit_len = LEN_W'(r_count);
                    end
                    n_esc      = 1'b0;
                    n_held     = 8'h00;
                    n_held_vld = 1'b0;
                    n_run_xor  = 8'h00;
                    n_count    = '0;
                    n_disc     = 1'b0;
                    n_phase    = PH_WAIT;
                end else if (r_phase == PH_DATA) begin
                    if (!r_esc && i_rx_byte == ESC_BYTE) begin
                        n_esc = 1'b1;
                    end else begin
                        n_esc = 1'b0;
                        if (!r_held_vld) begin
                            n_held     = w_dbyte;
                            n_held_vld = 1'b1;
                        end else if (r_count >= MAX_CNT) begin
                            // overlong: drop rest of frame
                            n_held     = 8'h00;
                            n_held_vld = 1'b0;
                            n_phase    = PH_SKIP;
                        end else begin
                            w_emit     = 1'b1;
                            w_emit_pay = r_held;
                            n_run_xor  = r_run_xor ^ r_held;
                            n_count    = r_count + 1'b1;
                            n_held     = w_dbyte;
                        end
                    end
                end
            end
            default: begin
                n_phase = (i_rx_byte == FLAG_BYTE) ? PH_FLAG : PH_WAIT;
            end
        endcase
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_hdr_xor  <= 8'h00;
            r_seq      <= 1'b0;
            r_disc     <= 1'b0;
            r_esc      <= 1'b0;
            r_held     <= 8'h00;
            r_held_vld <= 1'b0;
            r_run_xor  <= 8'h00;
            r_count    <= '0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_hdr_xor  <= n_hdr_xor;
            r_seq      <= n_seq;
            r_disc     <= n_disc;
            r_esc      <= n_esc;
            r_held     <= n_held;
            r_held_vld <= n_held_vld;
            r_run_xor  <= n_run_xor;
            r_count    <= n_count;
        end
    end

    // peer address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peer <= PEER_ADDR_RST;
        end else if (i_cfg_we) begin
            r_peer <= i_cfg_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_is_end  <= w_emit_end;
            r_pay     <= w_emit_pay;
            r_verdict <= w_emit_vd;
            r_len     <= w_emit_len;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_is_frame_end   = r_is_end;
    assign o_payload_byte   = r_pay;
    assign o_verdict        = r_verdict;
    assign o_payload_length = r_len;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_verdict_back_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit && w_emit_end) |=> (r_phase == PH_WAIT))
        else $error("parser not hunting after a verdict");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("payload count above limit");

    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_frame_end) |-> (o_verdict == 3'd0 && o_payload_length == '0))
        else $error("payload word carries verdict fields");

    a_held_only_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_DATA) |-> !r_held_vld)
        else $error("held byte outside payload phase");

endmodule

`default_nettype wire
